// ===== sv/clrq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clrq_pkg
// Shared types and defaults for the C-LOOK request queue.
// ----------------------------------------------------------------------------
package clrq_pkg;

	localparam int DEF_QUEUE_DEPTH = 16;
	localparam int DEF_SECTOR_BITS = 48;
	localparam int DEF_TAG_BITS    = 8;
	localparam int LEN_BITS        = 16;

	typedef enum logic [1:0] {
		ACT_ADD      = 2'd0,
		ACT_DISPATCH = 2'd1,
		ACT_REMOVE   = 2'd2,
		ACT_NOP      = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_EMPTY     = 2'd1,
		STS_FULL      = 2'd2,
		STS_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		MV_HOLD,
		MV_NEW,
		MV_LEFT,
		MV_RIGHT
	} slot_mv_t;

	typedef struct packed {
		logic     cap;
		slot_mv_t mv;
	} slot_ctl_t;

endpackage
`default_nettype wire

// ===== sv/clrq_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clrq_req_if
// Request channel: action plus request sector, length and tag.
// ----------------------------------------------------------------------------
interface clrq_req_if import clrq_pkg::*; #(
	parameter int SECTOR_BITS = DEF_SECTOR_BITS,
	parameter int TAG_BITS    = DEF_TAG_BITS
) ();
	logic                   valid;
	logic                   ready;
	logic [1:0]             action;
	logic [SECTOR_BITS-1:0] request_sector;
	logic [LEN_BITS-1:0]    request_length;
	logic [TAG_BITS-1:0]    request_tag;

	modport source (output valid, action, request_sector, request_length, request_tag,
		input ready);
	modport sink (input valid, action, request_sector, request_length, request_tag,
		output ready);
endinterface
`default_nettype wire

// ===== sv/clrq_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clrq_rsp_if
// Result channel: status, issued request, pending count and head position.
// ----------------------------------------------------------------------------
interface clrq_rsp_if import clrq_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int SECTOR_BITS = DEF_SECTOR_BITS,
	parameter int TAG_BITS    = DEF_TAG_BITS
) ();
	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	logic                   valid;
	logic                   ready;
	logic [1:0]             status;
	logic [SECTOR_BITS-1:0] issued_sector;
	logic [LEN_BITS-1:0]    issued_length;
	logic [TAG_BITS-1:0]    issued_tag;
	logic [CNT_BITS-1:0]    pending_count;
	logic [SECTOR_BITS-1:0] head_now;

	modport source (output valid, status, issued_sector, issued_length, issued_tag,
		pending_count, head_now, input ready);
	modport sink (input valid, status, issued_sector, issued_length, issued_tag,
		pending_count, head_now, output ready);
endinterface
`default_nettype wire

// ===== sv/c_look_request_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c_look_request_queue
// Bounded disk request queue kept in C-LOOK order as a row of slots.
//
// req (sink): one word per operation: add a request, dispatch the front
//   request, or remove a request by tag.
// rsp (source): one word per request word with status, the dispatched
//   request (zero unless dispatched), the pending count and the head.
// Each request word passes an accept cycle and the shift stage: in the accept
//   cycle every slot compares its entry against the incoming word and registers
//   the result; in the shift stage the first hit is resolved along the row, the
//   slots shift one place and the result word is loaded once the result register
//   is free. No new request word is accepted until that result word is loaded.
// Reset empties the queue and sets the head to zero, with no clearing pass.
// When the receiver stalls, the result word holds; one more request word is
//   accepted and waits in the shift stage until the result register frees.
// ----------------------------------------------------------------------------
module c_look_request_queue import clrq_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int SECTOR_BITS = DEF_SECTOR_BITS,
	parameter int TAG_BITS    = DEF_TAG_BITS
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	clrq_req_if.sink    req,
	clrq_rsp_if.source  rsp
);

	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {
		S_IDLE,
		S_APPLY
	} state_t;

	state_t                 state_q;
	action_t                op_s1;
	logic [SECTOR_BITS-1:0] sector_s1;
	logic [LEN_BITS-1:0]    length_s1;
	logic [TAG_BITS-1:0]    tag_s1;
	logic [SECTOR_BITS-1:0] head_q;
	logic [CNT_BITS-1:0]    count_q;
	logic                   rsp_valid_q;
	status_t                status_q;
	logic [SECTOR_BITS-1:0] issued_sector_q;
	logic [LEN_BITS-1:0]    issued_length_q;
	logic [TAG_BITS-1:0]    issued_tag_q;

	logic                   req_acc;
	logic                   apply;
	logic                   full;
	logic                   empty;
	logic [SECTOR_BITS-1:0] key_new;

	slot_ctl_t              ctl [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] slot_valid;
	logic [SECTOR_BITS-1:0] slot_sector [QUEUE_DEPTH];
	logic [LEN_BITS-1:0]    slot_length [QUEUE_DEPTH];
	logic [TAG_BITS-1:0]    slot_tag [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] gt;
	logic [QUEUE_DEPTH-1:0] match;
	logic [QUEUE_DEPTH:0]   gt_pre;
	logic [QUEUE_DEPTH:0]   match_pre;

	assign req.ready = (state_q == S_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign apply     = (state_q == S_APPLY) && (!rsp_valid_q || rsp.ready);
	assign full      = (count_q == CNT_BITS'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);
	assign key_new   = req.request_sector - head_q;

	assign gt_pre[0]    = 1'b0;
	assign match_pre[0] = 1'b0;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_slot
		logic                   lv;
		logic [SECTOR_BITS-1:0] ls;
		logic [LEN_BITS-1:0]    ll;
		logic [TAG_BITS-1:0]    lt;
		logic                   rv;
		logic [SECTOR_BITS-1:0] rs;
		logic [LEN_BITS-1:0]    rl;
		logic [TAG_BITS-1:0]    rt;

		assign gt_pre[i+1]    = gt_pre[i] | gt[i];
		assign match_pre[i+1] = match_pre[i] | match[i];

		if (i == 0) begin : g_first
			assign lv = 1'b0;
			assign ls = '0;
			assign ll = '0;
			assign lt = '0;
		end else begin : g_mid_l
			assign lv = slot_valid[i-1];
			assign ls = slot_sector[i-1];
			assign ll = slot_length[i-1];
			assign lt = slot_tag[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign rv = 1'b0;
			assign rs = '0;
			assign rl = '0;
			assign rt = '0;
		end else begin : g_mid_r
			assign rv = slot_valid[i+1];
			assign rs = slot_sector[i+1];
			assign rl = slot_length[i+1];
			assign rt = slot_tag[i+1];
		end

		always_comb begin
			ctl[i].cap = req_acc;
			ctl[i].mv  = MV_HOLD;
			if (apply) begin
				case (op_s1)
					ACT_ADD: begin
						if (!full) begin
							if (gt_pre[i]) begin
								ctl[i].mv = MV_LEFT;
							end else if (gt[i]) begin
								ctl[i].mv = MV_NEW;
							end
						end
					end
					ACT_DISPATCH: begin
						if (!empty) begin
							ctl[i].mv = MV_RIGHT;
						end
					end
					ACT_REMOVE: begin
						if (match_pre[i+1]) begin
							ctl[i].mv = MV_RIGHT;
						end
					end
					default: ctl[i].mv = MV_HOLD;
				endcase
			end
		end

		clrq_slot #(
			.SECTOR_BITS (SECTOR_BITS),
			.TAG_BITS    (TAG_BITS)
		) u_slot (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctl          (ctl[i]),
			.head         (head_q),
			.key_new      (key_new),
			.tag_cmp      (req.request_tag),
			.new_sector   (sector_s1),
			.new_length   (length_s1),
			.new_tag      (tag_s1),
			.left_valid   (lv),
			.left_sector  (ls),
			.left_length  (ll),
			.left_tag     (lt),
			.right_valid  (rv),
			.right_sector (rs),
			.right_length (rl),
			.right_tag    (rt),
			.valid        (slot_valid[i]),
			.sector       (slot_sector[i]),
			.length       (slot_length[i]),
			.tag          (slot_tag[i]),
			.gt_s1        (gt[i]),
			.match_s1     (match[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			op_s1           <= ACT_NOP;
			sector_s1       <= '0;
			length_s1       <= '0;
			tag_s1          <= '0;
			head_q          <= '0;
			count_q         <= '0;
			rsp_valid_q     <= 1'b0;
			status_q        <= STS_OK;
			issued_sector_q <= '0;
			issued_length_q <= '0;
			issued_tag_q    <= '0;
		end else begin
			if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						state_q   <= S_APPLY;
						op_s1     <= action_t'(req.action);
						sector_s1 <= req.request_sector;
						length_s1 <= req.request_length;
						tag_s1    <= req.request_tag;
					end
				end
				S_APPLY: begin
					if (apply) begin
						state_q         <= S_IDLE;
						rsp_valid_q     <= 1'b1;
						status_q        <= STS_OK;
						issued_sector_q <= '0;
						issued_length_q <= '0;
						issued_tag_q    <= '0;
						case (op_s1)
							ACT_ADD: begin
								if (full) begin
									status_q <= STS_FULL;
								end else begin
									count_q <= count_q + CNT_BITS'(1);
								end
							end
							ACT_DISPATCH: begin
								if (empty) begin
									status_q <= STS_EMPTY;
								end else begin
									issued_sector_q <= slot_sector[0];
									issued_length_q <= slot_length[0];
									issued_tag_q    <= slot_tag[0];
									head_q          <= slot_sector[0]
										+ SECTOR_BITS'(slot_length[0]);
									count_q         <= count_q - CNT_BITS'(1);
								end
							end
							ACT_REMOVE: begin
								if (match_pre[QUEUE_DEPTH]) begin
									count_q <= count_q - CNT_BITS'(1);
								end else begin
									status_q <= STS_NOT_FOUND;
								end
							end
							default: status_q <= STS_OK;
						endcase
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = status_q;
	assign rsp.issued_sector = issued_sector_q;
	assign rsp.issued_length = issued_length_q;
	assign rsp.issued_tag    = issued_tag_q;
	assign rsp.pending_count = count_q;
	assign rsp.head_now      = head_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(QUEUE_DEPTH))
		else $error("pending count above depth");

	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(slot_valid) == int'(count_q))
		else $error("slot valid bits disagree with pending count");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && (status_q == STS_FULL) |-> full)
		else $error("full status with room in queue");

	a_accept_apply: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> (state_q == S_APPLY))
		else $error("accepted word not taken to shift stage");

endmodule
`default_nettype wire

// ===== sv/clrq_slot.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clrq_slot
// One queue slot: holds a request, compares it against the incoming word
// and takes new, left or right neighbor contents on command.
// ----------------------------------------------------------------------------
module clrq_slot import clrq_pkg::*; #(
	parameter int SECTOR_BITS = DEF_SECTOR_BITS,
	parameter int TAG_BITS    = DEF_TAG_BITS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire slot_ctl_t              ctl,
	input  wire logic [SECTOR_BITS-1:0] head,
	input  wire logic [SECTOR_BITS-1:0] key_new,
	input  wire logic [TAG_BITS-1:0]    tag_cmp,
	input  wire logic [SECTOR_BITS-1:0] new_sector,
	input  wire logic [LEN_BITS-1:0]    new_length,
	input  wire logic [TAG_BITS-1:0]    new_tag,
	input  wire logic                   left_valid,
	input  wire logic [SECTOR_BITS-1:0] left_sector,
	input  wire logic [LEN_BITS-1:0]    left_length,
	input  wire logic [TAG_BITS-1:0]    left_tag,
	input  wire logic                   right_valid,
	input  wire logic [SECTOR_BITS-1:0] right_sector,
	input  wire logic [LEN_BITS-1:0]    right_length,
	input  wire logic [TAG_BITS-1:0]    right_tag,
	output logic                        valid,
	output logic [SECTOR_BITS-1:0]      sector,
	output logic [LEN_BITS-1:0]         length,
	output logic [TAG_BITS-1:0]         tag,
	output logic                        gt_s1,
	output logic                        match_s1
);

	logic                   valid_q;
	logic [SECTOR_BITS-1:0] sector_q;
	logic [LEN_BITS-1:0]    length_q;
	logic [TAG_BITS-1:0]    tag_q;
	logic [SECTOR_BITS-1:0] key;

	assign key = sector_q - head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (ctl.mv)
				MV_NEW:   valid_q <= 1'b1;
				MV_LEFT:  valid_q <= left_valid;
				MV_RIGHT: valid_q <= right_valid;
				default:  valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.mv)
			MV_NEW: begin
				sector_q <= new_sector;
				length_q <= new_length;
				tag_q    <= new_tag;
			end
			MV_LEFT: begin
				sector_q <= left_sector;
				length_q <= left_length;
				tag_q    <= left_tag;
			end
			MV_RIGHT: begin
				sector_q <= right_sector;
				length_q <= right_length;
				tag_q    <= right_tag;
			end
			default: begin
				sector_q <= sector_q;
				length_q <= length_q;
				tag_q    <= tag_q;
			end
		endcase
		// empty slot counts as farther ahead so inserts land at the tail
		if (ctl.cap) begin
			gt_s1    <= valid_q ? (key > key_new) : 1'b1;
			match_s1 <= valid_q && (tag_q == tag_cmp);
		end
	end

	assign valid  = valid_q;
	assign sector = sector_q;
	assign length = length_q;
	assign tag    = tag_q;

endmodule
`default_nettype wire
